// ===== hw/rtl/rtct_pkg.sv =====
// Shared types, reset values and the month-length table for the tick-driven
// real-time clock and calendar. No dependencies.

package rtct_pkg;

  // Configuration register indexes
  localparam logic [1:0] CfgSecPerMin  = 2'd0;
  localparam logic [1:0] CfgMinPerHour = 2'd1;
  localparam logic [1:0] CfgHourPerDay = 2'd2;

  localparam logic [5:0] SecPerMinReset  = 6'd60;
  localparam logic [5:0] MinPerHourReset = 6'd60;
  localparam logic [5:0] HourPerDayReset = 6'd24;

  localparam logic [5:0]  SecondReset  = 6'd0;
  localparam logic [5:0]  MinuteReset  = 6'd0;
  localparam logic [4:0]  HourReset    = 5'd4;
  localparam logic [2:0]  WeekdayReset = 3'd6;
  localparam logic [4:0]  DayReset     = 5'd26;
  localparam logic [3:0]  MonthReset   = 4'd3;
  localparam logic [15:0] YearReset    = 16'd2019;
  // Year split for the leap rule: year mod 100, and (year / 100) mod 4.
  localparam logic [6:0]  YearMod100Reset  = 7'd19;
  localparam logic [1:0]  CenturyMod4Reset = 2'd0;

  localparam logic [2:0]  WeekdayLast  = 3'd6;
  localparam logic [3:0]  MonthFirst   = 4'd1;
  localparam logic [3:0]  MonthLast    = 4'd12;
  localparam logic [4:0]  DayFirst     = 5'd1;
  localparam logic [4:0]  HourLast     = 5'd31;
  localparam logic [6:0]  YearMod100Last = 7'd99;
  localparam logic [15:0] YearLast     = 16'hFFFF;

  typedef struct packed {
    logic [5:0] sec_per_min;
    logic [5:0] min_per_hour;
    logic [5:0] hour_per_day;
  } cfg_t;

  typedef struct packed {
    logic [5:0] second;
    logic [5:0] minute;
    logic [4:0] hour;
  } time_t;

  typedef struct packed {
    logic [2:0]  weekday;
    logic [4:0]  day;
    logic [3:0]  month;
    logic [15:0] year;
    logic [6:0]  year_mod100;
    logic [1:0]  century_mod4;
  } date_t;

  // Days in a month; a month code outside 1..12 counts as 31 days.
  function automatic logic [4:0] month_length(input logic [3:0] month, input logic leap);
    logic [4:0] len;
    case (month)
      4'd2:                     len = leap ? 5'd29 : 5'd28;
      4'd4, 4'd6, 4'd9, 4'd11:  len = 5'd30;
      default:                  len = 5'd31;
    endcase
    return len;
  endfunction

  // Gregorian rule: divisible by 4 and not by 100, or divisible by 400.
  function automatic logic is_leap(input date_t d);
    return (d.year[1:0] == 2'd0) && ((d.year_mod100 != 7'd0) || (d.century_mod4 == 2'd0));
  endfunction

endpackage

// ===== hw/rtl/rtct_time_step.sv =====
// Second, minute and hour cascade for one tick; flags the day carry.
// Depends on rtct_pkg.

module rtct_time_step
  import rtct_pkg::*;
(
  input  cfg_t  cfg_i,
  input  time_t time_i,
  input  logic  advance_i,
  output time_t time_o,
  output logic  day_carry_o
);

  logic [5:0] sec_inc;
  logic [6:0] min_inc;
  logic [5:0] hour_inc;

  assign sec_inc  = time_i.second + 6'd1;
  assign min_inc  = {1'b0, time_i.minute} + 7'd1;
  assign hour_inc = {1'b0, time_i.hour} + 6'd1;

  always_comb begin
    time_o      = time_i;
    day_carry_o = 1'b0;
    if (advance_i) begin
      if (sec_inc < cfg_i.sec_per_min) begin
        time_o.second = sec_inc;
      end else begin
        time_o.second = '0;
        if (min_inc < {1'b0, cfg_i.min_per_hour}) begin
          time_o.minute = min_inc[5:0];
        end else begin
          time_o.minute = '0;
          // hour count is 5 bits: roll after hour 31 whatever the setting
          if ((hour_inc < cfg_i.hour_per_day) && (time_i.hour != HourLast)) begin
            time_o.hour = hour_inc[4:0];
          end else begin
            time_o.hour = '0;
            day_carry_o = 1'b1;
          end
        end
      end
    end
  end

endmodule

// ===== hw/rtl/rtct_date_step.sv =====
// Weekday, day, month and year advance on a day carry, with the leap rule.
// Depends on rtct_pkg.

module rtct_date_step
  import rtct_pkg::*;
(
  input  date_t date_i,
  input  logic  day_carry_i,
  output date_t date_o
);

  logic [4:0] mlen;

  assign mlen = month_length(date_i.month, is_leap(date_i));

  always_comb begin
    date_o = date_i;
    if (day_carry_i) begin
      date_o.weekday = (date_i.weekday >= WeekdayLast) ? 3'd0 : date_i.weekday + 3'd1;
      if (date_i.day < mlen) begin
        date_o.day = date_i.day + 5'd1;
      end else begin
        date_o.day = DayFirst;
        if ((date_i.month >= MonthFirst) && (date_i.month < MonthLast)) begin
          date_o.month = date_i.month + 4'd1;
        end else begin
          date_o.month = MonthFirst;
          date_o.year  = date_i.year + 16'd1;
          // keep the mod-100 and century-mod-4 split in step with the year
          if (date_i.year == YearLast) begin
            date_o.year_mod100  = '0;
            date_o.century_mod4 = '0;
          end else if (date_i.year_mod100 == YearMod100Last) begin
            date_o.year_mod100  = '0;
            date_o.century_mod4 = date_i.century_mod4 + 2'd1;
          end else begin
            date_o.year_mod100 = date_i.year_mod100 + 7'd1;
          end
        end
      end
    end
  end

endmodule

// ===== hw/rtl/rtc_calendar_tick.sv =====
// Top level of the tick-driven real-time clock and calendar: stream ports,
// configuration registers, state and result register. Depends on rtct_pkg,
// rtct_time_step and rtct_date_step.
//
//  channel   direction  handshake                  payload
//  s_axis    in         s_axis_tvalid/tready       tdata[0] advance
//  m_axis    out        m_axis_tvalid/tready       tdata[45:0] time and date
//  cfg       in         cfg_valid/cfg_ready        cfg_index, cfg_data
//
// The tick cascade and the calendar update are combinational between the
// state registers and the result register, and a new request is taken in
// every cycle while the result register is empty or drained in the same
// cycle. Reset loads weekday 6, 2019-03-26 04:00:00 and the default 60/60/24
// counts. A stall on m_axis holds the result and blocks s_axis; configuration
// writes are always taken.

module rtc_calendar_tick
  import rtct_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [7:0]  s_axis_tdata_i,  // [0] advance
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  // [5:0] second_now, [11:6] minute_now, [16:12] hour_now, [19:17] weekday_now,
  // [24:20] day_now, [28:25] month_now, [44:29] year_now, [45] leap_now
  output logic [47:0] m_axis_tdata_o,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [1:0]  cfg_index_i,
  input  logic [5:0]  cfg_data_i
);

  cfg_t        cfg_q;
  time_t       time_q, time_d;
  date_t       date_q, date_d;
  logic        day_carry;
  logic        in_take;
  logic        out_valid_q;
  logic [47:0] out_data_q;

  assign cfg_ready_o     = 1'b1;
  // Take a request when the result slot is free or being drained now.
  assign s_axis_tready_o = !out_valid_q || m_axis_tready_i;
  assign in_take         = s_axis_tvalid_i && s_axis_tready_o;

  rtct_time_step u_time (
    .cfg_i       (cfg_q),
    .time_i      (time_q),
    .advance_i   (s_axis_tdata_i[0]),
    .time_o      (time_d),
    .day_carry_o (day_carry)
  );

  rtct_date_step u_date (
    .date_i      (date_q),
    .day_carry_i (day_carry),
    .date_o      (date_d)
  );

  // Configuration registers; an index past the list is dropped.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.sec_per_min  <= SecPerMinReset;
      cfg_q.min_per_hour <= MinPerHourReset;
      cfg_q.hour_per_day <= HourPerDayReset;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        CfgSecPerMin:  cfg_q.sec_per_min  <= cfg_data_i;
        CfgMinPerHour: cfg_q.min_per_hour <= cfg_data_i;
        CfgHourPerDay: cfg_q.hour_per_day <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Clock and calendar state; advance only on a taken request.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      time_q.second       <= SecondReset;
      time_q.minute       <= MinuteReset;
      time_q.hour         <= HourReset;
      date_q.weekday      <= WeekdayReset;
      date_q.day          <= DayReset;
      date_q.month        <= MonthReset;
      date_q.year         <= YearReset;
      date_q.year_mod100  <= YearMod100Reset;
      date_q.century_mod4 <= CenturyMod4Reset;
    end else if (in_take) begin
      time_q <= time_d;
      date_q <= date_d;
    end
  end

  // Result register valid flag.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (in_take) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  // Result payload: report the time as it stands after this request.
  always_ff @(posedge clk_i) begin
    if (in_take) begin
      out_data_q <= {2'b00, is_leap(date_d), date_d.year, date_d.month, date_d.day,
                     date_d.weekday, time_d.hour, time_d.minute, time_d.second};
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = out_data_q;

endmodule
